// File: rtl/core/twc_pkg.sv
// Shared constants, types and replacement functions for the two-level cache.
package twc_pkg;

  localparam int ADDR_BITS   = 32;
  localparam int BLOCK_BYTES = 32;
  localparam int OFF_W       = $clog2(BLOCK_BYTES);
  localparam int BLK_W       = ADDR_BITS - OFF_W;

  localparam int L1_SETS   = 64;
  localparam int L1_WAYS   = 4;
  localparam int L1_SET_W  = $clog2(L1_SETS);
  localparam int L1_WAY_W  = $clog2(L1_WAYS);
  localparam int L1_TAG_W  = BLK_W - L1_SET_W;
  localparam int L1_TREE_W = L1_WAYS - 1;

  // L2_SETS is a multiple of L1_SETS: an L2 victim always maps to the current L1 set
  localparam int L2_SETS   = 512;
  localparam int L2_WAYS   = 8;
  localparam int L2_SET_W  = $clog2(L2_SETS);
  localparam int L2_WAY_W  = $clog2(L2_WAYS);
  localparam int L2_TAG_W  = BLK_W - L2_SET_W;
  localparam int L2_TREE_W = L2_WAYS - 1;

  localparam int CLR_W      = L2_SET_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;

  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLICY = 2'd0,
    CFG_INCL   = 2'd1,
    CFG_L2EN   = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_L1_RD, S_L1_EVAL, S_WB_RD, S_WB_EVAL, S_WB_UPD,
    S_FL_RD, S_FL_EVAL, S_FL_UPD, S_L1_WR, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    CMD_NONE, CMD_CLEAR, CMD_ACCEPT, CMD_L1_EVAL, CMD_L2_EVAL, CMD_L2_UPD, CMD_L1_WRITE
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic l1_hit;
    logic wb_need;
    logic l2_en;
  } status_t;

  typedef struct packed {
    logic [L1_WAYS-1:0][L1_TAG_W-1:0] tag;
    logic [L1_WAYS-1:0]               valid;
    logic [L1_WAYS-1:0]               dirty;
    logic [L1_WAYS-1:0][L1_WAY_W-1:0] rec;
    logic [L1_TREE_W-1:0]             tree;
  } l1_row_t;

  typedef struct packed {
    logic [L2_WAYS-1:0][L2_TAG_W-1:0] tag;
    logic [L2_WAYS-1:0]               valid;
    logic [L2_WAYS-1:0]               dirty;
    logic [L2_WAYS-1:0][L2_WAY_W-1:0] rec;
    logic [L2_TREE_W-1:0]             tree;
  } l2_row_t;

  function automatic l1_row_t l1_reset_row();
    l1_row_t r;
    r = '0;
    for (int i = 0; i < L1_WAYS; i++) r.rec[i] = L1_WAY_W'(i);
    return r;
  endfunction

  function automatic l2_row_t l2_reset_row();
    l2_row_t r;
    r = '0;
    for (int i = 0; i < L2_WAYS; i++) r.rec[i] = L2_WAY_W'(i);
    return r;
  endfunction

  // {hit, way}
  function automatic logic [L1_WAY_W:0] l1_find(l1_row_t r, logic [L1_TAG_W-1:0] t);
    logic [L1_WAY_W:0] res;
    res = '0;
    for (int i = L1_WAYS - 1; i >= 0; i--)
      if (r.valid[i] && r.tag[i] == t) res = {1'b1, L1_WAY_W'(i)};
    return res;
  endfunction

  function automatic logic [L2_WAY_W:0] l2_find(l2_row_t r, logic [L2_TAG_W-1:0] t);
    logic [L2_WAY_W:0] res;
    res = '0;
    for (int i = L2_WAYS - 1; i >= 0; i--)
      if (r.valid[i] && r.tag[i] == t) res = {1'b1, L2_WAY_W'(i)};
    return res;
  endfunction

  // lowest invalid way first, else LRU or tree victim
  function automatic logic [L1_WAY_W-1:0] l1_pick(l1_row_t r, logic plru);
    logic [L1_WAY_W-1:0] best;
    logic [L1_WAY_W:0]   k;
    best = '0;
    k    = '0;
    if (plru) begin
      for (int l = 0; l < L1_WAY_W; l++)
        k = {k[L1_WAY_W-1:0], 1'b0} + (r.tree[k[L1_WAY_W-1:0]] ? 2'd2 : 2'd1);
      best = L1_WAY_W'(k - (L1_WAY_W+1)'(L1_WAYS - 1));
    end else begin
      for (int i = 1; i < L1_WAYS; i++)
        if (r.rec[i] < r.rec[best]) best = L1_WAY_W'(i);
    end
    for (int i = L1_WAYS - 1; i >= 0; i--)
      if (!r.valid[i]) best = L1_WAY_W'(i);
    return best;
  endfunction

  function automatic logic [L2_WAY_W-1:0] l2_pick(l2_row_t r, logic plru);
    logic [L2_WAY_W-1:0] best;
    logic [L2_WAY_W:0]   k;
    best = '0;
    k    = '0;
    if (plru) begin
      for (int l = 0; l < L2_WAY_W; l++)
        k = {k[L2_WAY_W-1:0], 1'b0} + (r.tree[k[L2_WAY_W-1:0]] ? 2'd2 : 2'd1);
      best = L2_WAY_W'(k - (L2_WAY_W+1)'(L2_WAYS - 1));
    end else begin
      for (int i = 1; i < L2_WAYS; i++)
        if (r.rec[i] < r.rec[best]) best = L2_WAY_W'(i);
    end
    for (int i = L2_WAYS - 1; i >= 0; i--)
      if (!r.valid[i]) best = L2_WAY_W'(i);
    return best;
  endfunction

  // make way w most recent; point tree path away from it
  function automatic l1_row_t l1_touch(l1_row_t r, logic [L1_WAY_W-1:0] w);
    l1_row_t             o;
    logic [L1_WAY_W-1:0] old;
    logic [L1_WAY_W:0]   x;
    logic [L1_WAY_W:0]   p;
    o   = r;
    old = r.rec[w];
    for (int i = 0; i < L1_WAYS; i++)
      if (r.rec[i] > old) o.rec[i] = r.rec[i] - 1'b1;
    o.rec[w] = L1_WAY_W'(L1_WAYS - 1);
    x = {1'b0, w} + (L1_WAY_W+1)'(L1_WAYS - 1);
    for (int l = 0; l < L1_WAY_W; l++) begin
      p = (x - 1'b1) >> 1;
      o.tree[p[L1_WAY_W-1:0]] = x[0];
      x = p;
    end
    return o;
  endfunction

  function automatic l2_row_t l2_touch(l2_row_t r, logic [L2_WAY_W-1:0] w);
    l2_row_t             o;
    logic [L2_WAY_W-1:0] old;
    logic [L2_WAY_W:0]   x;
    logic [L2_WAY_W:0]   p;
    o   = r;
    old = r.rec[w];
    for (int i = 0; i < L2_WAYS; i++)
      if (r.rec[i] > old) o.rec[i] = r.rec[i] - 1'b1;
    o.rec[w] = L2_WAY_W'(L2_WAYS - 1);
    x = {1'b0, w} + (L2_WAY_W+1)'(L2_WAYS - 1);
    for (int l = 0; l < L2_WAY_W; l++) begin
      p = (x - 1'b1) >> 1;
      o.tree[p[L2_WAY_W-1:0]] = x[0];
      x = p;
    end
    return o;
  endfunction

endpackage

// File: rtl/core/twc_ram.sv
// Simple dual-port RAM, one write and one registered read port.
module twc_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// File: rtl/core/twc_ctrl.sv
// Sequencer for lookup, L2 write-back, L2 fill and L1 install.
module twc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             out_stall,
  input  twc_pkg::status_t st,
  output twc_pkg::cmd_t    cmd,
  output logic             sel_fill,
  output logic             in_stall,
  output logic             out_valid
);
  import twc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:   if (st.clr_done) state_nxt = S_IDLE;
      S_IDLE:    if (in_valid) state_nxt = S_L1_RD;
      S_L1_RD:   state_nxt = S_L1_EVAL;
      S_L1_EVAL: begin
        if (st.l1_hit)       state_nxt = S_L1_WR;
        else if (st.wb_need) state_nxt = S_WB_RD;
        else if (st.l2_en)   state_nxt = S_FL_RD;
        else                 state_nxt = S_L1_WR;
      end
      S_WB_RD:   state_nxt = S_WB_EVAL;
      S_WB_EVAL: state_nxt = S_WB_UPD;
      S_WB_UPD:  state_nxt = S_FL_RD;
      S_FL_RD:   state_nxt = S_FL_EVAL;
      S_FL_EVAL: state_nxt = S_FL_UPD;
      S_FL_UPD:  state_nxt = S_L1_WR;
      S_L1_WR:   state_nxt = S_OUT;
      S_OUT:     if (!out_stall) state_nxt = S_IDLE;
      default:   state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = CMD_NONE;
    sel_fill  = 1'b0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_CLEAR:   cmd = CMD_CLEAR;
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd = CMD_ACCEPT;
      end
      S_L1_EVAL: cmd = CMD_L1_EVAL;
      S_WB_EVAL: cmd = CMD_L2_EVAL;
      S_WB_UPD:  cmd = CMD_L2_UPD;
      S_FL_RD:   sel_fill = 1'b1;
      S_FL_EVAL: begin
        cmd      = CMD_L2_EVAL;
        sel_fill = 1'b1;
      end
      S_FL_UPD: begin
        cmd      = CMD_L2_UPD;
        sel_fill = 1'b1;
      end
      S_L1_WR:   cmd = CMD_L1_WRITE;
      S_OUT:     out_valid = 1'b1;
      default:   cmd = CMD_NONE;
    endcase
  end

  a_wb_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB_RD) |-> ($past(state_r) == S_L1_EVAL))
    else $error("write-back read not entered from L1 lookup");
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while result pending");
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (in_stall && !out_valid))
    else $error("channel active during memory sweep");
endmodule

// File: rtl/core/twc_dp.sv
// Cache datapath: set memories, row registers, replacement and event flags.
module twc_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  twc_pkg::cmd_t                    cmd,
  input  logic                             sel_fill,
  output twc_pkg::status_t                 st,
  input  logic                             in_opcode,
  input  logic [twc_pkg::ADDR_BITS-1:0]    in_byte_address,
  input  logic                             cfg_we,
  input  logic [twc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [twc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             out_l1_hit,
  output logic                             out_l1_writeback,
  output logic                             out_l2_fill_miss,
  output logic                             out_l2_victim_miss,
  output logic [1:0]                       out_l2_writebacks,
  output logic [1:0]                       out_back_inval_writebacks
);
  import twc_pkg::*;

  logic policy_r, incl_r, l2en_r;
  logic [CLR_W-1:0] clr_cnt_r;

  logic             op_r;
  logic [BLK_W-1:0] blk_r;
  l1_row_t          l1row_r, l1row_nxt;
  logic             l1_hit_r;
  logic [L1_WAY_W-1:0] l1_way_r;
  logic [L1_TAG_W-1:0] vic_tag_r;
  l2_row_t          l2row_r;
  logic             l2_hit_r;
  logic [L2_WAY_W-1:0] l2_way_r;

  logic       wb1_r, rmiss_r, wmiss_r;
  logic [1:0] wb2_r, binv_r;

  // memory ports
  logic                l1_we, l2_we;
  logic [L1_SET_W-1:0] l1_waddr;
  logic [L2_SET_W-1:0] l2_waddr;
  l1_row_t             l1_wdata, l1_rd;
  l2_row_t             l2_wdata, l2_rd;

  logic [L1_SET_W-1:0] l1_set;
  logic [L1_TAG_W-1:0] l1_tag;
  logic [BLK_W-1:0]    acc_blk;
  logic [L2_SET_W-1:0] l2_set;
  logic [L2_TAG_W-1:0] l2_tag;

  logic [L1_WAY_W:0]   l1_look;
  logic [L1_WAY_W-1:0] l1_vic;
  logic [L2_WAY_W:0]   l2_look;

  l2_row_t l2_upd;
  l1_row_t l1_binv;
  logic    binv_inc, wb2_inc;
  l1_row_t l1_fin;

  assign l1_set  = blk_r[L1_SET_W-1:0];
  assign l1_tag  = blk_r[BLK_W-1:L1_SET_W];
  assign acc_blk = sel_fill ? blk_r : {vic_tag_r, l1_set};
  assign l2_set  = acc_blk[L2_SET_W-1:0];
  assign l2_tag  = acc_blk[BLK_W-1:L2_SET_W];

  twc_ram #(.DEPTH(L1_SETS), .WIDTH($bits(l1_row_t))) u_l1_ram (
    .clk(clk), .we(l1_we), .waddr(l1_waddr), .wdata(l1_wdata),
    .raddr(l1_set), .rdata(l1_rd)
  );

  twc_ram #(.DEPTH(L2_SETS), .WIDTH($bits(l2_row_t))) u_l2_ram (
    .clk(clk), .we(l2_we), .waddr(l2_waddr), .wdata(l2_wdata),
    .raddr(l2_set), .rdata(l2_rd)
  );

  assign l1_look = l1_find(l1_rd, l1_tag);
  assign l1_vic  = l1_pick(l1_rd, policy_r);
  assign l2_look = l2_find(l2_rd, l2_tag);

  assign st.clr_done = (clr_cnt_r == CLR_W'(L2_SETS - 1));
  assign st.l1_hit   = l1_look[L1_WAY_W];
  assign st.wb_need  = l1_rd.valid[l1_vic] && l1_rd.dirty[l1_vic] && l2en_r;
  assign st.l2_en    = l2en_r;

  // L2 row update, with back-invalidation of the victim's L1 copy in inclusive mode
  always_comb begin
    logic [BLK_W-1:0]    vb;
    logic [L1_TAG_W-1:0] vt;
    logic                l1d;
    l2_upd   = l2row_r;
    l1_binv  = l1row_r;
    binv_inc = 1'b0;
    wb2_inc  = 1'b0;
    l1d      = 1'b0;
    vb       = {l2row_r.tag[l2_way_r], l2_set};
    vt       = vb[BLK_W-1:L1_SET_W];
    if (!l2_hit_r && l2row_r.valid[l2_way_r]) begin
      if (incl_r) begin
        for (int i = 0; i < L1_WAYS; i++) begin
          if (l1row_r.valid[i] && l1row_r.tag[i] == vt) begin
            l1_binv.valid[i] = 1'b0;
            l1d              = l1row_r.dirty[i];
          end
        end
      end
      binv_inc = l1d;
      wb2_inc  = l2row_r.dirty[l2_way_r] && !l1d;
    end
    if (l2_hit_r) begin
      if (!sel_fill) l2_upd.dirty[l2_way_r] = 1'b1;
    end else begin
      l2_upd.tag[l2_way_r]   = l2_tag;
      l2_upd.valid[l2_way_r] = 1'b1;
      l2_upd.dirty[l2_way_r] = !sel_fill;
    end
    l2_upd = l2_touch(l2_upd, l2_way_r);
  end

  // final L1 row: refresh on hit, install on miss
  always_comb begin
    l1_fin = l1row_r;
    if (l1_hit_r) begin
      if (op_r == OP_WRITE) l1_fin.dirty[l1_way_r] = 1'b1;
    end else begin
      l1_fin.tag[l1_way_r]   = l1_tag;
      l1_fin.valid[l1_way_r] = 1'b1;
      l1_fin.dirty[l1_way_r] = (op_r == OP_WRITE);
    end
    l1_fin = l1_touch(l1_fin, l1_way_r);
  end

  always_comb begin
    l1row_nxt = l1row_r;
    case (cmd)
      CMD_L1_EVAL: begin
        l1row_nxt = l1_rd;
        if (!l1_look[L1_WAY_W]) l1row_nxt.valid[l1_vic] = 1'b0;
      end
      CMD_L2_UPD: l1row_nxt = l1_binv;
      default:    l1row_nxt = l1row_r;
    endcase
  end

  always_comb begin
    l1_we    = 1'b0;
    l2_we    = 1'b0;
    l1_waddr = l1_set;
    l2_waddr = l2_set;
    l1_wdata = l1_fin;
    l2_wdata = l2_upd;
    case (cmd)
      CMD_CLEAR: begin
        l1_we    = 1'b1;
        l2_we    = 1'b1;
        l1_waddr = clr_cnt_r[L1_SET_W-1:0];
        l2_waddr = clr_cnt_r[L2_SET_W-1:0];
        l1_wdata = l1_reset_row();
        l2_wdata = l2_reset_row();
      end
      CMD_L2_UPD:   l2_we = 1'b1;
      CMD_L1_WRITE: l1_we = 1'b1;
      default:      l1_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r  <= 1'b0;
      incl_r    <= 1'b0;
      l2en_r    <= 1'b1;
      clr_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_POLICY: policy_r <= cfg_data[0];
          CFG_INCL:   incl_r   <= cfg_data[0];
          CFG_L2EN:   l2en_r   <= cfg_data[0];
          default:    ;
        endcase
      end
      if (cmd == CMD_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    l1row_r <= l1row_nxt;
    case (cmd)
      CMD_ACCEPT: begin
        op_r    <= in_opcode;
        blk_r   <= in_byte_address[ADDR_BITS-1:OFF_W];
        wb1_r   <= 1'b0;
        rmiss_r <= 1'b0;
        wmiss_r <= 1'b0;
        wb2_r   <= '0;
        binv_r  <= '0;
      end
      CMD_L1_EVAL: begin
        l1_hit_r  <= l1_look[L1_WAY_W];
        l1_way_r  <= l1_look[L1_WAY_W] ? l1_look[L1_WAY_W-1:0] : l1_vic;
        vic_tag_r <= l1_rd.tag[l1_vic];
        wb1_r     <= !l1_look[L1_WAY_W] && l1_rd.valid[l1_vic] && l1_rd.dirty[l1_vic];
      end
      CMD_L2_EVAL: begin
        l2row_r  <= l2_rd;
        l2_hit_r <= l2_look[L2_WAY_W];
        l2_way_r <= l2_look[L2_WAY_W] ? l2_look[L2_WAY_W-1:0] : l2_pick(l2_rd, policy_r);
      end
      CMD_L2_UPD: begin
        if (!l2_hit_r) begin
          if (sel_fill) rmiss_r <= 1'b1;
          else          wmiss_r <= 1'b1;
        end
        binv_r <= binv_r + {1'b0, binv_inc};
        wb2_r  <= wb2_r + {1'b0, wb2_inc};
      end
      default: ;
    endcase
  end

  assign out_l1_hit                = l1_hit_r;
  assign out_l1_writeback          = wb1_r;
  assign out_l2_fill_miss          = rmiss_r;
  assign out_l2_victim_miss        = wmiss_r;
  assign out_l2_writebacks         = wb2_r;
  assign out_back_inval_writebacks = binv_r;

  a_no_l2_events: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_L1_WRITE && !l2en_r) |->
      (!rmiss_r && !wmiss_r && wb2_r == 2'd0 && binv_r == 2'd0))
    else $error("L2 event flagged with L2 disabled");
  a_evict_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_L1_WRITE) |-> (({1'b0, wb2_r} + {1'b0, binv_r}) <= 3'd2))
    else $error("more than two L2 evictions in one access");
  a_hit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_L1_WRITE && l1_hit_r) |-> (!wb1_r && !rmiss_r && !wmiss_r))
    else $error("miss activity on an L1 hit");
endmodule

// File: rtl/core/two_level_writeback_cache.sv
// Two-level write-back cache tracker, one access at a time (in_stall high while busy).
// Each access runs L1 read and evaluate; on a miss with L2 on it adds a write-back read,
// evaluate and update when the L1 victim is dirty, then a fill read, evaluate and update;
// it ends with the L1 write and the result, and holds the block until the result is taken.
// Every L2 step works on one set row in the registered-read set memories.
// Synchronous active-low reset, then a sweep over the 512 L2 set rows initializes both tag
// stores before the first access is taken; configuration writes are accepted throughout.
module two_level_writeback_cache (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_opcode,
  input  logic [twc_pkg::ADDR_BITS-1:0]  in_byte_address,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_l1_hit,
  output logic                           out_l1_writeback,
  output logic                           out_l2_fill_miss,
  output logic                           out_l2_victim_miss,
  output logic [1:0]                     out_l2_writebacks,
  output logic [1:0]                     out_back_inval_writebacks,
  input  logic                           cfg_we,
  input  logic [twc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [twc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import twc_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic    sel_fill;

  twc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .out_stall(out_stall),
    .st(st), .cmd(cmd), .sel_fill(sel_fill), .in_stall(in_stall), .out_valid(out_valid)
  );

  twc_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sel_fill(sel_fill), .st(st),
    .in_opcode(in_opcode), .in_byte_address(in_byte_address),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_l1_hit(out_l1_hit), .out_l1_writeback(out_l1_writeback),
    .out_l2_fill_miss(out_l2_fill_miss), .out_l2_victim_miss(out_l2_victim_miss),
    .out_l2_writebacks(out_l2_writebacks),
    .out_back_inval_writebacks(out_back_inval_writebacks)
  );
endmodule

// File: test/tb.sv
// Self-checking testbench for the two-level write-back cache tracker.
`timescale 1ns / 100ps

module tb;
  import twc_pkg::*;

  typedef struct {
    bit       l1_hit;
    bit       l1_wb;
    bit       l2_rd_miss;
    bit       l2_wr_miss;
    bit [1:0] l2_wbs;
    bit [1:0] binv_wbs;
  } access_res_t;

  typedef struct {
    bit          op;
    bit [31:0]   addr;
    bit          typed;
    access_res_t res;
  } access_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_opcode;
  logic [31:0] in_byte_address;
  logic        out_valid;
  logic        out_stall;
  logic        out_l1_hit;
  logic        out_l1_writeback;
  logic        out_l2_fill_miss;
  logic        out_l2_victim_miss;
  logic [1:0]  out_l2_writebacks;
  logic [1:0]  out_back_inval_writebacks;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  two_level_writeback_cache dut (.*);

  // shadow cache state
  bit [20:0] t1_tag [64][4];
  bit        t1_vld [64][4];
  bit        t1_dty [64][4];
  int        t1_rec [64][4];
  bit [2:0]  t1_tree[64];
  bit [17:0] t2_tag [512][8];
  bit        t2_vld [512][8];
  bit        t2_dty [512][8];
  int        t2_rec [512][8];
  bit [6:0]  t2_tree[512];
  bit        use_plru, inclusive, l2_on;

  access_res_t expected_q[$];
  access_row_t rows[$];
  int          errors;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void touch_l1(int s, int w);
    int old, x, p;
    old = t1_rec[s][w];
    for (int i = 0; i < 4; i++) if (t1_rec[s][i] > old) t1_rec[s][i]--;
    t1_rec[s][w] = 3;
    x = w + 3;
    while (x > 0) begin
      p = (x - 1) / 2;
      t1_tree[s][p] = x[0];
      x = p;
    end
  endfunction

  function automatic void touch_l2(int s, int w);
    int old, x, p;
    old = t2_rec[s][w];
    for (int i = 0; i < 8; i++) if (t2_rec[s][i] > old) t2_rec[s][i]--;
    t2_rec[s][w] = 7;
    x = w + 7;
    while (x > 0) begin
      p = (x - 1) / 2;
      t2_tree[s][p] = x[0];
      x = p;
    end
  endfunction

  function automatic int victim_l1(int s);
    int best, k;
    best = 0;
    k = 0;
    for (int i = 0; i < 4; i++) if (!t1_vld[s][i]) return i;
    if (!use_plru) begin
      for (int i = 1; i < 4; i++) if (t1_rec[s][i] < t1_rec[s][best]) best = i;
      return best;
    end
    while (k < 3) k = t1_tree[s][k] ? 2 * k + 2 : 2 * k + 1;
    return k - 3;
  endfunction

  function automatic int victim_l2(int s);
    int best, k;
    best = 0;
    k = 0;
    for (int i = 0; i < 8; i++) if (!t2_vld[s][i]) return i;
    if (!use_plru) begin
      for (int i = 1; i < 8; i++) if (t2_rec[s][i] < t2_rec[s][best]) best = i;
      return best;
    end
    while (k < 7) k = t2_tree[s][k] ? 2 * k + 2 : 2 * k + 1;
    return k - 7;
  endfunction

  // drop the L1 copy of an L2 victim; returns whether it was dirty
  function automatic bit back_invalidate(bit [26:0] blk);
    int s;
    s = int'(blk[5:0]);
    for (int i = 0; i < 4; i++)
      if (t1_vld[s][i] && t1_tag[s][i] == blk[26:6]) begin
        t1_vld[s][i] = 0;
        return t1_dty[s][i];
      end
    return 0;
  endfunction

  function automatic void l2_lookup(bit [26:0] blk, bit wr, inout access_res_t r);
    int s, w;
    bit l1d;
    s = int'(blk[8:0]);
    for (int i = 0; i < 8; i++)
      if (t2_vld[s][i] && t2_tag[s][i] == blk[26:9]) begin
        touch_l2(s, i);
        if (wr) t2_dty[s][i] = 1;
        return;
      end
    if (wr) r.l2_wr_miss = 1;
    else r.l2_rd_miss = 1;
    w = victim_l2(s);
    if (t2_vld[s][w]) begin
      l1d = 0;
      if (inclusive) begin
        l1d = back_invalidate({t2_tag[s][w], s[8:0]});
        if (l1d) r.binv_wbs++;
      end
      if (t2_dty[s][w] && !l1d) r.l2_wbs++;
    end
    t2_tag[s][w] = blk[26:9];
    t2_vld[s][w] = 1;
    t2_dty[s][w] = wr;
    touch_l2(s, w);
  endfunction

  function automatic access_res_t predict_access(bit wr, bit [31:0] addr);
    access_res_t r;
    bit [26:0] blk;
    int s, w;
    r = '{default: 0};
    blk = addr[31:5];
    s = int'(blk[5:0]);
    for (int i = 0; i < 4; i++)
      if (t1_vld[s][i] && t1_tag[s][i] == blk[26:6]) begin
        touch_l1(s, i);
        if (wr) t1_dty[s][i] = 1;
        r.l1_hit = 1;
        return r;
      end
    w = victim_l1(s);
    if (t1_vld[s][w]) begin
      t1_vld[s][w] = 0;
      if (t1_dty[s][w]) begin
        r.l1_wb = 1;
        if (l2_on) l2_lookup({t1_tag[s][w], s[5:0]}, 1, r);
      end
    end
    if (l2_on) l2_lookup(blk, 0, r);
    t1_tag[s][w] = blk[26:6];
    t1_vld[s][w] = 1;
    t1_dty[s][w] = wr;
    touch_l1(s, w);
    return r;
  endfunction

  function automatic void add_row(bit op, bit [31:0] addr, bit typed, access_res_t res);
    access_row_t r;
    r.op = op;
    r.addr = addr;
    r.typed = typed;
    r.res = res;
    rows.insert(rows.size(), r);
  endfunction

  task automatic write_cfg(cfg_idx_t idx, bit val);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    case (idx)
      CFG_POLICY: use_plru = val;
      CFG_INCL:   inclusive = val;
      default:    l2_on = val;
    endcase
  endtask

  task automatic drain_results();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (15) @(posedge clk);
    @(negedge clk);
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_access(access_row_t row);
    access_res_t pr;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 18));
    repeat (gap) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_opcode = row.op;
    in_byte_address = row.addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pr = predict_access(row.op, row.addr);
    expected_q.insert(expected_q.size(), row.typed ? row.res : pr);
    @(negedge clk);
    in_valid = 0;
  endtask

  function automatic bit [31:0] conflict_addr();
    bit [17:0] tg;
    bit [8:0]  s2;
    if ($urandom_range(0, 9) == 0) return $urandom;
    tg = 18'($urandom_range(0, 11));
    if ($urandom_range(0, 3) == 0) tg = tg | 18'h3FFF0;
    s2 = 9'($urandom_range(0, 3) * 64 + $urandom_range(0, 1));
    return {tg, s2, 5'($urandom_range(0, 31))};
  endfunction

  // receiver: random stall before each result
  initial begin
    int k;
    out_stall = 1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      k = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 18));
      out_stall = 1;
      repeat (k) @(negedge clk);
      out_stall = 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    access_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_l1_hit !== e.l1_hit) begin
          $error("l1_hit exp %0d got %0d", e.l1_hit, out_l1_hit); errors++;
        end
        if (out_l1_writeback !== e.l1_wb) begin
          $error("l1_writeback exp %0d got %0d", e.l1_wb, out_l1_writeback); errors++;
        end
        if (out_l2_fill_miss !== e.l2_rd_miss) begin
          $error("l2_fill_miss exp %0d got %0d", e.l2_rd_miss, out_l2_fill_miss); errors++;
        end
        if (out_l2_victim_miss !== e.l2_wr_miss) begin
          $error("l2_victim_miss exp %0d got %0d", e.l2_wr_miss, out_l2_victim_miss);
          errors++;
        end
        if (out_l2_writebacks !== e.l2_wbs) begin
          $error("l2_writebacks exp %0d got %0d", e.l2_wbs, out_l2_writebacks); errors++;
        end
        if (out_back_inval_writebacks !== e.binv_wbs) begin
          $error("back_inval_writebacks exp %0d got %0d", e.binv_wbs,
                 out_back_inval_writebacks);
          errors++;
        end
      end
    end
  end

  initial begin
    access_row_t row;
    bit pol_set[7] = '{0, 1, 1, 0, 1, 0, 0};
    bit inc_set[7] = '{0, 0, 1, 1, 1, 0, 1};
    bit en_set[7]  = '{1, 1, 1, 1, 0, 0, 1};
    errors = 0;
    rst_n = 0;
    in_valid = 0;
    in_opcode = 0;
    in_byte_address = '0;
    cfg_we = 0;
    cfg_index = CFG_POLICY;
    cfg_data = 0;
    for (int s = 0; s < 64; s++) begin
      t1_tree[s] = '0;
      for (int i = 0; i < 4; i++) begin
        t1_vld[s][i] = 0; t1_dty[s][i] = 0; t1_rec[s][i] = i; t1_tag[s][i] = '0;
      end
    end
    for (int s = 0; s < 512; s++) begin
      t2_tree[s] = '0;
      for (int i = 0; i < 8; i++) begin
        t2_vld[s][i] = 0; t2_dty[s][i] = 0; t2_rec[s][i] = i; t2_tag[s][i] = '0;
      end
    end
    use_plru = 0;
    inclusive = 0;
    l2_on = 1;
    repeat (8) @(posedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed: cold misses, hits, offset extremes, set conflicts, L2 conflicts
    add_row(0, 32'h0000_0000, 1, '{0, 0, 1, 0, 0, 0});
    add_row(1, 32'h0000_0000, 1, '{1, 0, 0, 0, 0, 0});
    add_row(0, 32'hFFFF_FFFF, 1, '{0, 0, 1, 0, 0, 0});
    add_row(1, 32'h0000_001F, 1, '{1, 0, 0, 0, 0, 0});
    add_row(1, 32'h0000_0800, 1, '{0, 0, 1, 0, 0, 0});
    add_row(1, 32'hFFFF_FFE0, 1, '{1, 0, 0, 0, 0, 0});
    add_row(1, 32'h0000_1000, 0, '{default: 0});
    add_row(0, 32'h0000_1800, 0, '{default: 0});
    add_row(1, 32'h0000_2000, 0, '{default: 0});
    add_row(0, 32'hAAAA_AAAA, 0, '{default: 0});
    add_row(1, 32'h5555_5555, 0, '{default: 0});
    for (int k = 1; k <= 10; k++)
      add_row(1, 32'(k) << 14, 0, '{default: 0});
    add_row(0, 32'h0000_0000, 0, '{default: 0});
    add_row(0, 32'h0000_0800, 0, '{default: 0});

    write_cfg(CFG_POLICY, 0);
    write_cfg(CFG_INCL, 0);
    write_cfg(CFG_L2EN, 1);
    foreach (rows[i]) send_access(rows[i]);

    for (int ph = 0; ph < 7; ph++) begin
      drain_results();
      write_cfg(CFG_POLICY, pol_set[ph]);
      write_cfg(CFG_INCL, inc_set[ph]);
      write_cfg(CFG_L2EN, en_set[ph]);
      for (int n = 0; n < 55; n++) begin
        if (ph == 2 && n == 25) drain_results();
        row.op = 1'($urandom_range(0, 1));
        row.addr = conflict_addr();
        row.typed = 0;
        row.res = '{default: 0};
        send_access(row);
      end
    end

    drain_results();
    if (errors == 0 && expected_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/twc_pkg.sv
rtl/core/twc_ram.sv
rtl/core/twc_ctrl.sv
rtl/core/twc_dp.sv
rtl/core/two_level_writeback_cache.sv
test/tb.sv
